// ===== sv/interleave_grid_overlay_macros.svh =====
// Assertion macros shared by the grid overlay RTL.
// Expects clk and arst_n in the scope of each use; no other dependencies.
`ifndef INTERLEAVE_GRID_OVERLAY_MACROS_SVH
`define INTERLEAVE_GRID_OVERLAY_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IGO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define IGO_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define IGO_ASSERT_IMP(lbl, ante, cons, msg)
`define IGO_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/igo_pkg.sv =====
// Shared types and constants for the grid overlay block.
// No dependencies; imported by every module of the block.
`default_nettype none

package igo_pkg;

	localparam int MAX_DIM = 2048;
	localparam int DIM_W   = 12;
	localparam int PER_W   = 11;
	localparam int PIX_W   = 32;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int SM_W    = 7;
	localparam int CNT_W   = 4;

	// register index (paddr[4:2])
	localparam logic [2:0] REG_MODE      = 3'd0;
	localparam logic [2:0] REG_TARGET_X  = 3'd1;
	localparam logic [2:0] REG_TARGET_Y  = 3'd2;
	localparam logic [2:0] REG_BEAT_X    = 3'd3;
	localparam logic [2:0] REG_BEAT_Y    = 3'd4;
	localparam logic [2:0] REG_COLOR     = 3'd5;
	localparam logic [2:0] REG_BEAT_JUMP = 3'd6;
	localparam logic [2:0] REG_SMOOTHING = 3'd7;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_REPLACE = 2'd1,
		MODE_SAT_ADD = 2'd2,
		MODE_AVERAGE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_SM1,
		ST_SM2,
		ST_DIV,
		ST_LOAD,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		mode_t              mode;
		logic [PER_W-1:0]   target_x;
		logic [PER_W-1:0]   target_y;
		logic [PER_W-1:0]   beat_x;
		logic [PER_W-1:0]   beat_y;
		logic [PIX_W-1:0]   color;
		logic               beat_jump;
		logic [SM_W-1:0]    smoothing;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic hold;        // latch frame-start word
		logic run_live;    // process live word into output register
		logic pass_live;   // disabled frame start: pass word, drop frame
		logic smooth_mul;  // register smoothing products
		logic smooth_upd;  // update periods, start remainder units
		logic load_frame;  // set up frame counters
		logic run_held;    // process latched word into output register
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_busy;
		logic out_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/igo_rem.sv =====
// Restoring remainder unit: one quotient bit per cycle over the dividend.
// Depends on igo_pkg for the dimension and period widths.
`default_nettype none

module igo_rem
	import igo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [DIM_W-1:0]   dividend,
	input  wire logic [PER_W-1:0]   divisor,
	output logic                    busy,
	output logic [PER_W-1:0]        rem
);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIM_W-1:0]   dvd_q;
	logic [PER_W-1:0]   dsr_q;
	logic [PER_W-1:0]   rem_q;
	logic [PER_W:0]     trial;
	logic [PER_W:0]     diff;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[DIM_W-1]};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIM_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, dsr_q}) ? diff[PER_W-1:0] : trial[PER_W-1:0];
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== sv/igo_dp.sv =====
// Datapath: period smoothing, remainder units, stripe counters, blend, output register.
// Depends on igo_pkg, igo_rem and the assertion macros header.
`default_nettype none
`include "interleave_grid_overlay_macros.svh"

module igo_dp
	import igo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire dp_cmd_t            cmd,
	output dp_stat_t                stat,
	input  wire logic [PIX_W-1:0]   pixel_in,
	input  wire logic               beat,
	input  wire logic [DIM_W-1:0]   frame_width,
	input  wire logic [DIM_W-1:0]   frame_height,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [PIX_W-1:0]        pixel_out
);

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0) return DIM_W'(1);
		if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W-1:0] r;
		logic [8:0]       c;
		r = '0;
		for (int i = 0; i < PIX_W / 8; i++) begin
			c = {1'b0, a[8*i +: 8]} + {1'b0, b[8*i +: 8]};
			r[8*i +: 8] = c[8] ? 8'hFF : c[7:0];
		end
		return r;
	endfunction

	// frame state
	logic signed [PER_W-1:0] smoothed_x_q, smoothed_y_q;
	logic signed [PER_W-1:0] period_x_q, period_y_q;
	logic                    frame_active_q;
	logic [PER_W-1:0]        fco_q;
	logic [DIM_W-1:0]        lwidth_q;
	logic [PER_W-1:0]        row_phase_q;
	logic                    row_open_q;
	logic [DIM_W-1:0]        col_pos_q;
	logic [DIM_W-1:0]        col_rem_q;
	logic                    col_skip_q;

	// latched frame-start word
	logic [PIX_W-1:0]        hold_pix_q;
	logic [DIM_W-1:0]        hold_w_q, hold_h_q;
	logic                    hold_beat_q;

	// smoothing products
	logic signed [21:0]      prod_cx_q, prod_cy_q;
	logic signed [18:0]      prod_tx_q, prod_ty_q;

	logic                    out_valid_q;
	logic [PIX_W-1:0]        pixel_out_q;

	// smoothing weights
	logic [SM_W-1:0]         k;
	logic [9:0]              wc;
	logic signed [10:0]      wc_s;
	logic signed [7:0]       wt_s;
	logic signed [21:0]      prod_cx, prod_cy;
	logic signed [18:0]      prod_tx, prod_ty;

	always_comb begin
		k    = (cfg.smoothing > SM_W'(64)) ? SM_W'(64) : cfg.smoothing;
		wc   = 10'(k) + 10'd448;
		wc_s = $signed({1'b0, wc});
		wt_s = $signed({1'b0, SM_W'(64) - k});
	end

	assign prod_cx = smoothed_x_q * wc_s;
	assign prod_cy = smoothed_y_q * wc_s;
	assign prod_tx = $signed(cfg.target_x) * wt_s;
	assign prod_ty = $signed(cfg.target_y) * wt_s;

	// sum, divide by 512 toward zero, beat override
	logic signed [22:0]      sum_x, sum_y, adj_x, adj_y, shr_x, shr_y;
	logic signed [PER_W-1:0] new_x, new_y;
	logic                    jump;

	always_comb begin
		sum_x = prod_cx_q + prod_tx_q;
		sum_y = prod_cy_q + prod_ty_q;
		adj_x = sum_x[22] ? sum_x + 23'sd511 : sum_x;
		adj_y = sum_y[22] ? sum_y + 23'sd511 : sum_y;
		shr_x = adj_x >>> 9;
		shr_y = adj_y >>> 9;
		jump  = hold_beat_q && cfg.beat_jump;
		new_x = jump ? $signed(cfg.beat_x) : shr_x[PER_W-1:0];
		new_y = jump ? $signed(cfg.beat_y) : shr_y[PER_W-1:0];
	end

	// remainder units for the stripe offsets
	logic             busy_x, busy_y;
	logic [PER_W-1:0] rem_x, rem_y;

	igo_rem u_rem_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.smooth_upd),
		.dividend (hold_w_q),
		.divisor  (new_x),
		.busy     (busy_x),
		.rem      (rem_x)
	);

	igo_rem u_rem_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.smooth_upd),
		.dividend (hold_h_q),
		.divisor  (new_y),
		.busy     (busy_y),
		.rem      (rem_y)
	);

	// per-word stripe step
	logic [PIX_W-1:0] pix_src;
	logic             step_en, load_out;
	logic [PER_W-1:0] tx, ty;
	logic             col0;
	logic [PER_W:0]   rp_inc;
	logic [PER_W-1:0] row_phase_d;
	logic             row_open_d;
	logic [DIM_W-1:0] cr_eff, cr_dec, col_rem_d;
	logic             skip_eff, col_skip_d;
	logic             covered;
	logic [DIM_W:0]   cp_inc;
	logic [DIM_W-1:0] col_pos_d;
	logic [PIX_W-1:0] blend, res;

	always_comb begin
		pix_src  = cmd.run_held ? hold_pix_q : pixel_in;
		step_en  = (cmd.run_live || cmd.run_held) && frame_active_q;
		load_out = cmd.run_live || cmd.run_held || cmd.pass_live;
		tx       = period_x_q;
		ty       = period_y_q;
		col0     = (col_pos_q == '0);

		// row band at row start
		rp_inc      = {1'b0, row_phase_q} + 1'b1;
		row_phase_d = row_phase_q;
		row_open_d  = row_open_q;
		if (col0 && ty != '0) begin
			if (rp_inc >= {1'b0, ty}) begin
				row_open_d  = !row_open_q;
				row_phase_d = '0;
			end else begin
				row_phase_d = rp_inc[PER_W-1:0];
			end
		end

		cr_eff   = col0 ? ({1'b0, tx} - {1'b0, fco_q}) : col_rem_q;
		skip_eff = col0 ? 1'b0 : col_skip_q;
		covered  = !row_open_d || (tx != '0 && !skip_eff);

		// column run countdown
		col_rem_d  = cr_eff;
		col_skip_d = skip_eff;
		cr_dec     = (cr_eff != '0) ? cr_eff - 1'b1 : cr_eff;
		if (tx != '0) begin
			col_rem_d = cr_dec;
			if (cr_dec == '0) begin
				col_skip_d = !skip_eff;
				col_rem_d  = {1'b0, tx};
			end
		end

		cp_inc    = {1'b0, col_pos_q} + 1'b1;
		col_pos_d = (cp_inc >= {1'b0, lwidth_q}) ? '0 : cp_inc[DIM_W-1:0];

		case (cfg.mode)
			MODE_REPLACE: blend = cfg.color;
			MODE_SAT_ADD: blend = sat_add(pix_src, cfg.color);
			MODE_AVERAGE: blend = ((pix_src >> 1) & 32'h7F7F7F7F)
				+ ((cfg.color >> 1) & 32'h7F7F7F7F);
			default:      blend = pix_src;
		endcase
		res = (step_en && covered) ? blend : pix_src;
	end

	// frame state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_x_q   <= PER_W'(1);
			smoothed_y_q   <= PER_W'(1);
			period_x_q     <= '0;
			period_y_q     <= '0;
			frame_active_q <= 1'b0;
			fco_q          <= '0;
			lwidth_q       <= '0;
			row_phase_q    <= '0;
			row_open_q     <= 1'b0;
			col_pos_q      <= '0;
			col_rem_q      <= '0;
			col_skip_q     <= 1'b0;
		end else begin
			if (cmd.hold || cmd.pass_live) frame_active_q <= 1'b0;
			if (cmd.smooth_upd) begin
				smoothed_x_q <= new_x;
				smoothed_y_q <= new_y;
				period_x_q   <= new_x;
				period_y_q   <= new_y;
			end
			if (cmd.load_frame) begin
				lwidth_q       <= hold_w_q;
				fco_q          <= (period_x_q > 0) ? {1'b0, rem_x[PER_W-1:1]} : '0;
				row_phase_q    <= (period_y_q > 0) ? {1'b0, rem_y[PER_W-1:1]} : '0;
				row_open_q     <= (period_y_q == '0);
				col_pos_q      <= '0;
				col_rem_q      <= '0;
				col_skip_q     <= 1'b0;
				frame_active_q <= !period_x_q[PER_W-1] && !period_y_q[PER_W-1];
			end
			if (step_en) begin
				row_phase_q <= row_phase_d;
				row_open_q  <= row_open_d;
				col_rem_q   <= col_rem_d;
				col_skip_q  <= col_skip_d;
				col_pos_q   <= col_pos_d;
			end
		end
	end

	// latched word and products
	always_ff @(posedge clk) begin
		if (cmd.hold) begin
			hold_pix_q  <= pixel_in;
			hold_w_q    <= clamp_dim(frame_width);
			hold_h_q    <= clamp_dim(frame_height);
			hold_beat_q <= beat;
		end
		if (cmd.smooth_mul) begin
			prod_cx_q <= prod_cx;
			prod_cy_q <= prod_cy;
			prod_tx_q <= prod_tx;
			prod_ty_q <= prod_ty;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) pixel_out_q <= res;
	end

	assign out_valid     = out_valid_q;
	assign pixel_out     = pixel_out_q;
	assign stat.div_busy = busy_x || busy_y;
	assign stat.out_busy = out_valid_q && out_stall;

	`IGO_ASSERT_NXT(a_out_loaded, load_out, out_valid_q, "output word not registered")
	`IGO_ASSERT_IMP(a_row_phase_bound, frame_active_q && !period_y_q[PER_W-1] && period_y_q != '0, row_phase_q < period_y_q, "row phase past period")
	`IGO_ASSERT_IMP(a_col_rem_bound, frame_active_q && !period_x_q[PER_W-1], col_rem_q <= {1'b0, period_x_q}, "column run count past period")

endmodule

`default_nettype wire

// ===== sv/igo_ctrl.sv =====
// Controller: frame-start sequencing and input handshake for the overlay datapath.
// Depends on igo_pkg and the assertion macros header.
`default_nettype none
`include "interleave_grid_overlay_macros.svh"

module igo_ctrl
	import igo_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire logic     frame_start,
	input  wire logic     mode_on,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_RUN;
		else         state_q <= state_d;
	end

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_RUN: begin
				in_stall = stat.out_busy;
				if (in_valid && !stat.out_busy) begin
					if (frame_start && mode_on) begin
						cmd.hold = 1'b1;
						state_d  = ST_SM1;
					end else if (frame_start) begin
						cmd.pass_live = 1'b1;
					end else begin
						cmd.run_live = 1'b1;
					end
				end
			end
			ST_SM1: begin
				cmd.smooth_mul = 1'b1;
				state_d        = ST_SM2;
			end
			ST_SM2: begin
				cmd.smooth_upd = 1'b1;
				state_d        = ST_DIV;
			end
			ST_DIV: begin
				if (!stat.div_busy) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_frame = 1'b1;
				state_d        = ST_EMIT;
			end
			ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.run_held = 1'b1;
					state_d      = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	`IGO_ASSERT_IMP(a_accept_in_run, in_valid && !in_stall, state_q == ST_RUN, "word taken outside run state")
	`IGO_ASSERT_NXT(a_fs_sequence, state_q == ST_RUN && in_valid && !in_stall && frame_start && mode_on, state_q == ST_SM1, "frame start did not enter smoothing")
	`IGO_ASSERT_NXT(a_div_started, state_q == ST_SM2, stat.div_busy, "remainder units not started")

endmodule

`default_nettype wire

// ===== sv/interleave_grid_overlay.sv =====
// Top level of the grid stripe overlay: APB register file, controller and datapath.
// Depends on igo_pkg, igo_ctrl, igo_dp (and igo_rem below it).
`default_nettype none

// Grid stripe overlay on a raster pixel stream. Ordinary pixels are taken one per
// clock unless the output register is stalled, and appear in the output register
// in the next cycle. A frame-start pixel with the overlay enabled goes through period
// smoothing (multiply, then add and scale), 12 bit steps in the bit-serial remainder
// units that find the stripe offsets from the frame size, a wait for them to finish,
// frame setup and the pixel itself. in_stall is held high through this sequence, and
// longer while the output register is stalled. With mode 0 a frame start passes through.
// Registers sit at byte addresses 4*i: mode, target_x, target_y, beat_x, beat_y,
// overlay_color, beat_jump, smoothing; write them only while the block is idle.

module interleave_grid_overlay
	import igo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	// input words
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [PIX_W-1:0]   pixel_in,
	input  wire logic               frame_start,
	input  wire logic               beat,
	input  wire logic [DIM_W-1:0]   frame_width,
	input  wire logic [DIM_W-1:0]   frame_height,
	// output words
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [PIX_W-1:0]        pixel_out
);

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;
	dp_cmd_t    cmd;
	dp_stat_t   stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode      <= MODE_REPLACE;
			cfg_q.target_x  <= PER_W'(1);
			cfg_q.target_y  <= PER_W'(1);
			cfg_q.beat_x    <= PER_W'(1);
			cfg_q.beat_y    <= PER_W'(1);
			cfg_q.color     <= '0;
			cfg_q.beat_jump <= 1'b0;
			cfg_q.smoothing <= SM_W'(4);
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:      cfg_q.mode      <= mode_t'(pwdata[1:0]);
				REG_TARGET_X:  cfg_q.target_x  <= pwdata[PER_W-1:0];
				REG_TARGET_Y:  cfg_q.target_y  <= pwdata[PER_W-1:0];
				REG_BEAT_X:    cfg_q.beat_x    <= pwdata[PER_W-1:0];
				REG_BEAT_Y:    cfg_q.beat_y    <= pwdata[PER_W-1:0];
				REG_COLOR:     cfg_q.color     <= pwdata[PIX_W-1:0];
				REG_BEAT_JUMP: cfg_q.beat_jump <= pwdata[0];
				REG_SMOOTHING: cfg_q.smoothing <= pwdata[SM_W-1:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (reg_idx)
			REG_MODE:      prdata = {{(DATA_W-2){1'b0}}, cfg_q.mode};
			REG_TARGET_X:  prdata = {{(DATA_W-PER_W){1'b0}}, cfg_q.target_x};
			REG_TARGET_Y:  prdata = {{(DATA_W-PER_W){1'b0}}, cfg_q.target_y};
			REG_BEAT_X:    prdata = {{(DATA_W-PER_W){1'b0}}, cfg_q.beat_x};
			REG_BEAT_Y:    prdata = {{(DATA_W-PER_W){1'b0}}, cfg_q.beat_y};
			REG_COLOR:     prdata = cfg_q.color;
			REG_BEAT_JUMP: prdata = {{(DATA_W-1){1'b0}}, cfg_q.beat_jump};
			REG_SMOOTHING: prdata = {{(DATA_W-SM_W){1'b0}}, cfg_q.smoothing};
			default:       prdata = '0;
		endcase
	end

	igo_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.frame_start (frame_start),
		.mode_on     (cfg_q.mode != MODE_OFF),
		.stat        (stat),
		.cmd         (cmd)
	);

	igo_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.stat         (stat),
		.pixel_in     (pixel_in),
		.beat         (beat),
		.frame_width  (frame_width),
		.frame_height (frame_height),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_out    (pixel_out)
	);

endmodule

`default_nettype wire
